[src/ipd_pkg.sv]
package ipd_pkg;

    localparam int SPEED_W = 16;
    localparam int GAIN_W  = 16;
    localparam int BOUND_W = 8;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = BOUND_W + FRAC_W;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int PP_W    = ERR_W + GAIN_W;
    localparam int DP_W    = DIFF_W + GAIN_W;
    localparam int SUM_W   = DP_W + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [SPEED_W-1:0] TARGET_FLOOR  = 16'd100;
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST = 16'd66;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = 16'd131;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_SPEED = 3'd0,
        CFG_PROP_GAIN    = 3'd1,
        CFG_DERIV_GAIN   = 3'd2,
        CFG_LEVEL_MIN    = 3'd3,
        CFG_LEVEL_MAX    = 3'd4,
        CFG_DRIVE_MIN    = 3'd5,
        CFG_DRIVE_MAX    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [SPEED_W-1:0] target_speed;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [BOUND_W-1:0] level_min;
        logic [BOUND_W-1:0] level_max;
        logic [BOUND_W-1:0] drive_min;
        logic [BOUND_W-1:0] drive_max;
    } t_cfg;

    // products stage toward the accumulator stage
    typedef struct packed {
        logic                     valid;
        logic signed [ERR_W-1:0]  err;
        logic signed [PP_W-1:0]   p_term;
        logic signed [DP_W-1:0]   d_term;
    } t_prod;

endpackage

[src/ipd_cfg_regs.sv]
module ipd_cfg_regs
    import ipd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_speed <= '0;
            r_cfg.prop_gain    <= PROP_GAIN_RST;
            r_cfg.deriv_gain   <= DERIV_GAIN_RST;
            r_cfg.level_min    <= '0;
            r_cfg.level_max    <= '1;
            r_cfg.drive_min    <= '0;
            r_cfg.drive_max    <= '1;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TARGET_SPEED: r_cfg.target_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_PROP_GAIN:    r_cfg.prop_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:   r_cfg.deriv_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_LEVEL_MIN:    r_cfg.level_min    <= i_cfg_data[BOUND_W-1:0];
                CFG_LEVEL_MAX:    r_cfg.level_max    <= i_cfg_data[BOUND_W-1:0];
                CFG_DRIVE_MIN:    r_cfg.drive_min    <= i_cfg_data[BOUND_W-1:0];
                CFG_DRIVE_MAX:    r_cfg.drive_max    <= i_cfg_data[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[src/ipd_err_stage.sv]
module ipd_err_stage
    import ipd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [SPEED_W-1:0] i_measured_speed,
    input  logic               i_next_ready,
    output t_prod              o_prod
);

    logic                     r_a_valid;
    logic [SPEED_W-1:0]       r_meas;
    logic signed [ERR_W-1:0]  r_last_error;
    logic                     r_prod_valid;
    logic signed [ERR_W-1:0]  r_prod_err;
    logic signed [PP_W-1:0]   r_p_term;
    logic signed [DP_W-1:0]   r_d_term;

    logic                       w_ready_a;
    logic                       w_ready_b;
    logic                       w_a_move;
    logic signed [ERR_W-1:0]    w_err;
    logic signed [DIFF_W-1:0]   w_diff;
    logic signed [PP_W:0]       w_p_full;
    logic signed [DP_W:0]       w_d_full;

    assign w_ready_b = !r_prod_valid || i_next_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign w_a_move  = r_a_valid && w_ready_b;
    assign o_in_ready = w_ready_a;

    assign w_err  = $signed({1'b0, i_cfg.target_speed}) - $signed({1'b0, r_meas});
    assign w_diff = DIFF_W'(w_err) - DIFF_W'(r_last_error);
    assign w_p_full = w_err * $signed({1'b0, i_cfg.prop_gain});
    assign w_d_full = w_diff * $signed({1'b0, i_cfg.deriv_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid    <= 1'b0;
            r_prod_valid <= 1'b0;
            r_last_error <= '0;
        end else begin
            if (w_ready_a) begin
                r_a_valid <= i_in_valid;
            end
            if (w_ready_b) begin
                r_prod_valid <= r_a_valid;
            end
            if (w_a_move) begin
                r_last_error <= w_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_in_valid) begin
            r_meas <= i_measured_speed;
        end
        if (w_a_move) begin
            r_prod_err <= w_err;
            r_p_term   <= $signed(w_p_full[PP_W-1:0]);
            r_d_term   <= $signed(w_d_full[DP_W-1:0]);
        end
    end

    assign o_prod = '{valid: r_prod_valid, err: r_prod_err, p_term: r_p_term,
                      d_term: r_d_term};

`ifndef SYNTHESIS
    a_last_error_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_a_move |=> $stable(r_last_error))
        else $error("last error changed without a request moving on");

    a_prod_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_prod_valid && !i_next_ready) |=> r_prod_valid)
        else $error("stalled product stage lost its request");
`endif

endmodule

[src/ipd_acc_stage.sv]
module ipd_acc_stage
    import ipd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  t_prod                    i_prod,
    output logic                     o_ready,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [BOUND_W-1:0]       o_drive_level,
    output logic signed [ERR_W-1:0]  o_speed_error
);

    logic                     r_out_valid;
    logic [ACC_W-1:0]         r_acc;
    logic [BOUND_W-1:0]       r_drive;
    logic signed [ERR_W-1:0]  r_err;

    logic                      w_ready_c;
    logic                      w_move;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [SUM_W-1:0]   w_hi;
    logic signed [SUM_W-1:0]   w_lo;
    logic signed [SUM_W-1:0]   w_clamped;
    logic [ACC_W-1:0]          n_acc;
    logic [BOUND_W-1:0]        w_int;
    logic [BOUND_W-1:0]        n_drive;

    assign w_ready_c = !r_out_valid || i_out_ready;
    assign w_move    = i_prod.valid && w_ready_c;
    assign o_ready   = w_ready_c;

    assign w_sum = $signed({{(SUM_W-ACC_W){1'b0}}, r_acc})
                 + SUM_W'(i_prod.p_term) + SUM_W'(i_prod.d_term);
    assign w_hi = $signed({{(SUM_W-ACC_W){1'b0}}, i_cfg.level_max, {FRAC_W{1'b0}}});
    assign w_lo = $signed({{(SUM_W-ACC_W){1'b0}}, i_cfg.level_min, {FRAC_W{1'b0}}});

    always_comb begin
        priority if (w_sum > w_hi) begin
            w_clamped = w_hi;
        end else if (w_sum < w_lo) begin
            w_clamped = w_lo;
        end else begin
            w_clamped = w_sum;
        end
        // low target parks the accumulator at zero
        if (i_cfg.target_speed < TARGET_FLOOR) begin
            n_acc = '0;
        end else begin
            n_acc = w_clamped[ACC_W-1:0];
        end
        w_int = n_acc[ACC_W-1:FRAC_W];
        priority if (w_int > i_cfg.drive_max) begin
            n_drive = i_cfg.drive_max;
        end else if (w_int < i_cfg.drive_min) begin
            n_drive = i_cfg.drive_min;
        end else begin
            n_drive = w_int;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_acc       <= '0;
        end else begin
            if (w_ready_c) begin
                r_out_valid <= i_prod.valid;
            end
            if (w_move) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_drive <= n_drive;
            r_err   <= i_prod.err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_level = r_drive;
    assign o_speed_error = r_err;

`ifndef SYNTHESIS
    a_acc_ceiling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_acc[ACC_W-1:FRAC_W] == {BOUND_W{1'b1}}) |-> (r_acc[FRAC_W-1:0] == '0))
        else $error("drive accumulator above its full-scale value");

    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_move |=> $stable(r_acc))
        else $error("drive accumulator changed without a request");
`endif

endmodule

[src/incremental_pd_speed_controller_top.sv]
// incremental pd speed controller: each request carries one measured speed sample;
// the block forms error = target - measured and its change since the last sample,
// adds prop_gain*error + deriv_gain*change (gains are unsigned q0.16) to a q8.16
// drive accumulator, clamps it to [level_min, level_max] and forces it to zero
// while the target is below 100 rpm; the result is the integer part of the
// accumulator clamped to [drive_min, drive_max] together with the 17-bit signed
// error. one request is taken every cycle while the output is not stalled; each
// result passes the input register, which loads on the edge that takes its
// request, then the product register, then the output register; the rate is set
// by the accumulator loop, whose add and clamp are combinational.
// configuration registers are to be written through the plain write port while
// idle, which the block itself does not enforce; writes to index 7 are ignored.
module incremental_pd_speed_controller_top
    import ipd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // speed sample requests
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [SPEED_W-1:0]       i_measured_speed,
    // drive results
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [BOUND_W-1:0]       o_drive_level,
    output logic signed [ERR_W-1:0]  o_speed_error
);

    t_cfg  w_cfg;
    t_prod w_prod;
    logic  w_acc_ready;

    // register file for target, gains and clamp bounds
    ipd_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // input register, error and difference, both gain products
    ipd_err_stage u_err_stage (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_measured_speed (i_measured_speed),
        .i_next_ready     (w_acc_ready),
        .o_prod           (w_prod)
    );

    // accumulator update, clamps and output register
    ipd_acc_stage u_acc_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_prod        (w_prod),
        .o_ready       (w_acc_ready),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_drive_level (o_drive_level),
        .o_speed_error (o_speed_error)
    );

endmodule
